// ----- design/csbf_pkg.sv -----
// shared types, constants and helpers for the clipped sprite blitter
// used by csbf_ctrl, csbf_dpath and clipped_sprite_blit_framebuffer
// no dependencies
package csbf_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int ADDR_W        = $clog2(SCREEN_WIDTH);
  localparam int WORD_W        = 64;

  // item field widths
  localparam int COORD_W = 8;
  localparam int WIDE_W  = COORD_W + 1;
  localparam int ROWS_W  = 7;
  localparam int PAGE_W  = 3;
  localparam int SCOL_W  = 7;
  localparam int SHIFT_W = $clog2(WORD_W);
  localparam int BYTE_W  = 8;
  localparam logic [ROWS_W-1:0] MAX_ROWS = ROWS_W'(WORD_W);

  // stream widths
  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TUSER_W = 1;
  localparam int OUT_TDATA_W = 72;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_LEFT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_TOP  = 1'b1;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_DRAW_OR   = 3'd1,
    OP_DRAW_SET  = 3'd2,
    OP_READ_COL  = 3'd3,
    OP_READ_BYTE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MEM
  } state_e;

  // one input word, unpacked
  typedef struct packed {
    op_e                 operation;
    logic [COORD_W-1:0]  sprite_left;
    logic [COORD_W-1:0]  sprite_top;
    logic [COORD_W-1:0]  sprite_columns;
    logic [ROWS_W-1:0]   sprite_rows;
    logic [COORD_W-1:0]  column_number;
    logic [WORD_W-1:0]   column_pixels;
    logic [PAGE_W-1:0]   page_number;
    logic [SCOL_W-1:0]   screen_column;
  } in_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic clear;
    logic write;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic vis;
  } status_t;

  // mask of the n lowest bits, n up to the word width
  function automatic logic [WORD_W-1:0] low_bits(logic [ROWS_W-1:0] n);
    logic [WORD_W-1:0] r;
    if (n >= MAX_ROWS) begin
      r = '1;
    end else begin
      r = (WORD_W'(8'h01) << n) - WORD_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- design/clipped_sprite_blit_framebuffer.sv -----
// a read result is registered at the end of the memory step that follows its clip step
// a new word is taken only once the last has passed accept, clip and memory read, then write
// or result, the frame memory read-modify-write; the result step waits while the output stalls
// a frame clear or an unused code skips the memory step; a clear drops all valid bits at once
// reset: frame reads as all zeros at once, camera registers zero, no clearing pass
// top level; depends on csbf_pkg, csbf_ctrl, csbf_dpath
module clipped_sprite_blit_framebuffer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csbf_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [csbf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sprite_left, sprite_top, sprite_columns, sprite_rows, column_number,
  // column_pixels, page_number, screen_column, zero pad
  input  logic [csbf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // operation
  input  logic [csbf_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // read_pixels, display_byte
  output logic [csbf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // column_visible
  output logic [csbf_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
  import csbf_pkg::*;

  in_item_t          item;
  cmd_t              cmd;
  status_t           status;
  logic [WORD_W-1:0] read_pixels;
  logic              column_visible;
  logic [BYTE_W-1:0] display_byte;

  // unpack the input word
  assign item.operation      = op_e'(s_axis_tuser);
  assign item.sprite_left    = s_axis_tdata[7:0];
  assign item.sprite_top     = s_axis_tdata[15:8];
  assign item.sprite_columns = s_axis_tdata[23:16];
  assign item.sprite_rows    = s_axis_tdata[30:24];
  assign item.column_number  = s_axis_tdata[38:31];
  assign item.column_pixels  = s_axis_tdata[102:39];
  assign item.page_number    = s_axis_tdata[105:103];
  assign item.screen_column  = s_axis_tdata[112:106];

  csbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csbf_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .item_i           (item),
    .cmd_i            (cmd),
    .status_o         (status),
    .read_pixels_o    (read_pixels),
    .column_visible_o (column_visible),
    .display_byte_o   (display_byte)
  );

  // pack the output word
  assign m_axis_tdata = {display_byte, read_pixels};
  assign m_axis_tuser = column_visible;

  // every accepted word is clipped in the next cycle
  a_load_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.calc)
    else $error("accepted word not followed by clip step");

  // a result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // frame writes only for visible columns and never during a clear
  a_write_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write |-> (status.vis && !cmd.clear))
    else $error("frame write without visible column");

  // no new word taken during the clip step
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.calc |-> !s_axis_tready)
    else $error("input ready during clip step");

endmodule

// ----- design/csbf_ctrl.sv -----
// controller state machine of the sprite blitter
// sequences accept, clip and memory read, then write or result; a clear or unused code ends after the clip
// depends on csbf_pkg
module csbf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  csbf_pkg::status_t status_i,
  output csbf_pkg::cmd_t    cmd_o
);
  import csbf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        unique case (status_i.op) inside
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
          OP_DRAW_OR, OP_DRAW_SET, OP_READ_COL, OP_READ_BYTE: begin
            state_d = ST_MEM;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MEM: begin
        unique case (status_i.op) inside
          OP_DRAW_OR, OP_DRAW_SET: begin
            cmd_o.write = status_i.vis;
            state_d     = ST_IDLE;
          end
          default: begin
            // result waits for a free output register
            if (!out_valid_q || out_ready_i) begin
              cmd_o.emit = 1'b1;
              state_d    = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/csbf_dpath.sv -----
// datapath of the sprite blitter: clipping, frame memory, merge and readout
// frame memory is one word per screen column with a valid bit per word
// depends on csbf_pkg
module csbf_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csbf_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [csbf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  csbf_pkg::in_item_t                   item_i,
  input  csbf_pkg::cmd_t                       cmd_i,
  output csbf_pkg::status_t                    status_o,
  output logic [csbf_pkg::WORD_W-1:0]          read_pixels_o,
  output logic                                 column_visible_o,
  output logic [csbf_pkg::BYTE_W-1:0]          display_byte_o
);
  import csbf_pkg::*;

  // camera registers
  logic [COORD_W-1:0] cam_left_q, cam_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_left_q <= '0;
      cam_top_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CAMERA_LEFT: cam_left_q <= cfg_data_i;
        CFG_CAMERA_TOP:  cam_top_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched input word
  in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // clip the sprite column against the camera window
  logic [ROWS_W-1:0]  rows_c;
  logic [WIDE_W-1:0]  wx_c, x_end_c, e1_c, e2_c, ye_c, hi_c;
  logic [COORD_W-1:0] ys_c, lo_c, diff_c;
  logic               below_c, vis_c;
  logic [WIDE_W-1:0]  sx_full_c;
  logic [WORD_W-1:0]  mask_c;
  logic [ADDR_W-1:0]  rd_addr_c;
  logic               byte_ok_c;

  always_comb begin
    rows_c    = (item_q.sprite_rows > MAX_ROWS) ? MAX_ROWS : item_q.sprite_rows;
    wx_c      = {1'b0, item_q.sprite_left} + {1'b0, item_q.column_number};
    x_end_c   = {1'b0, cam_left_q} + WIDE_W'(SCREEN_WIDTH);
    below_c   = item_q.sprite_top >= cam_top_q;
    ys_c      = below_c ? item_q.sprite_top : cam_top_q;
    e1_c      = {1'b0, item_q.sprite_top} + {{(WIDE_W-ROWS_W){1'b0}}, rows_c};
    e2_c      = {1'b0, cam_top_q} + WIDE_W'(SCREEN_HEIGHT);
    ye_c      = (e1_c < e2_c) ? e1_c : e2_c;
    vis_c     = (item_q.column_number < item_q.sprite_columns)
                && (wx_c >= {1'b0, cam_left_q}) && (wx_c < x_end_c)
                && ({1'b0, ys_c} < ye_c);
    hi_c      = ye_c - {1'b0, item_q.sprite_top};
    lo_c      = ys_c - item_q.sprite_top;
    diff_c    = below_c ? (item_q.sprite_top - cam_top_q)
                        : (cam_top_q - item_q.sprite_top);
    mask_c    = vis_c ? (low_bits(hi_c[ROWS_W-1:0]) & ~low_bits(lo_c[ROWS_W-1:0]))
                      : '0;
    sx_full_c = wx_c - {1'b0, cam_left_q};
    byte_ok_c = {1'b0, item_q.screen_column} < (SCOL_W+1)'(SCREEN_WIDTH);
    if (item_q.operation == OP_READ_BYTE) begin
      rd_addr_c = ADDR_W'(item_q.screen_column);
    end else begin
      rd_addr_c = sx_full_c[ADDR_W-1:0];
    end
  end

  // clip results
  logic                vis_q, below_q, byte_ok_q;
  logic [SHIFT_W-1:0]  shamt_q;
  logic [WORD_W-1:0]   mask_q;
  logic [ADDR_W-1:0]   addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= 1'b0;
    end else if (cmd_i.calc) begin
      vis_q <= vis_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      below_q   <= below_c;
      shamt_q   <= diff_c[SHIFT_W-1:0];
      mask_q    <= mask_c;
      addr_q    <= rd_addr_c;
      byte_ok_q <= byte_ok_c;
    end
  end

  // frame memory with per-word valid bits
  logic [WORD_W-1:0]       mem_q [SCREEN_WIDTH];
  logic [SCREEN_WIDTH-1:0] valid_q;
  logic [WORD_W-1:0]       rd_word_q;
  logic                    rd_ok_q;
  logic [WORD_W-1:0]       new_word_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[addr_q] <= new_word_c;
    end
    if (cmd_i.calc) begin
      rd_word_q <= mem_q[rd_addr_c];
      rd_ok_q   <= valid_q[rd_addr_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (cmd_i.write) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // merge and readout
  logic [WORD_W-1:0] word_c, col_rd_c, bits_c, placed_c, scr_mask_c;
  logic [BYTE_W-1:0] byte_c;

  always_comb begin
    word_c     = rd_ok_q ? rd_word_q : '0;
    col_rd_c   = (below_q ? (word_c >> shamt_q) : (word_c << shamt_q)) & mask_q;
    bits_c     = item_q.column_pixels & mask_q;
    placed_c   = below_q ? (bits_c << shamt_q) : (bits_c >> shamt_q);
    scr_mask_c = below_q ? (mask_q << shamt_q) : (mask_q >> shamt_q);
    new_word_c = ((item_q.operation == OP_DRAW_SET) ? (word_c & ~scr_mask_c) : word_c)
                 | (placed_c & scr_mask_c);
    byte_c     = byte_ok_q ? word_c[{item_q.page_number, 3'b000} +: BYTE_W] : '0;
  end

  // output register
  logic [WORD_W-1:0] out_pix_q;
  logic              out_vis_q;
  logic [BYTE_W-1:0] out_byte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (item_q.operation == OP_READ_BYTE) begin
        out_pix_q  <= '0;
        out_vis_q  <= 1'b0;
        out_byte_q <= byte_c;
      end else begin
        out_pix_q  <= col_rd_c;
        out_vis_q  <= vis_q;
        out_byte_q <= '0;
      end
    end
  end

  assign read_pixels_o    = out_pix_q;
  assign column_visible_o = out_vis_q;
  assign display_byte_o   = out_byte_q;
  assign status_o.op      = item_q.operation;
  assign status_o.vis     = vis_q;

endmodule

// ----- bench/clipped_sprite_blit_framebuffer_tb.sv -----
// self-checking bench for the clipped sprite blitter: directed rows, then random words
// under six camera settings; a local frame model predicts each read result that has no hand-typed one
// depends on csbf_pkg and clipped_sprite_blit_framebuffer
`timescale 1ns / 100ps

module clipped_sprite_blit_framebuffer_tb;
  import csbf_pkg::*;

  // spare operation codes, ignored by the block
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int DRAIN_TAIL     = 10;
  localparam int WORDS_PER_PASS = 140;
  localparam int NUM_PASSES     = 6;

  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] sprite_left;
    logic [COORD_W-1:0] sprite_top;
    logic [COORD_W-1:0] sprite_columns;
    logic [ROWS_W-1:0]  sprite_rows;
    logic [COORD_W-1:0] column_number;
    logic [WORD_W-1:0]  column_pixels;
    logic [PAGE_W-1:0]  page_number;
    logic [SCOL_W-1:0]  screen_column;
  } blit_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_pixels;
    logic              column_visible;
    logic [BYTE_W-1:0] display_byte;
  } blit_res_t;

  typedef struct {
    blit_item_t w;
    bit         typed;
    blit_res_t  res;
  } blit_row_t;

  localparam blit_res_t RES_ZERO     = '{64'd0, 1'b0, 8'd0};
  localparam blit_res_t RES_ZERO_VIS = '{64'd0, 1'b1, 8'd0};

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // word on the bus, with its hand-typed result if it has one
  blit_item_t drv_item      = '0;
  bit         drv_typed     = 1'b0;
  blit_res_t  drv_typed_res = '0;

  // frame model and camera
  logic [WORD_W-1:0] frame_model [SCREEN_WIDTH];
  int                cam_left_m;
  int                cam_top_m;
  blit_res_t         pending_results [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int errors          = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int draws_sent      = 0;

  blit_row_t dir_rows [$];

  clipped_sprite_blit_framebuffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("clipped_sprite_blit_framebuffer_tb: errors");
    $finish;
  end

  // mask of the n lowest bits
  function automatic logic [WORD_W-1:0] mask_below(int n);
    if (n >= WORD_W) return '1;
    return (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

  // tdata layout, listed from the highest field down to sprite_left in the lowest bits
  function automatic logic [IN_TDATA_W-1:0] pack_word(blit_item_t w);
    return IN_TDATA_W'({w.screen_column, w.page_number, w.column_pixels, w.column_number,
                        w.sprite_rows, w.sprite_columns, w.sprite_top, w.sprite_left});
  endfunction

  function automatic blit_item_t mk(logic [2:0] op, int sx, int sy, int cols, int rows,
                                    int colno, logic [WORD_W-1:0] pix, int page, int scol);
    blit_item_t w;
    w.op             = op;
    w.sprite_left    = COORD_W'(sx);
    w.sprite_top     = COORD_W'(sy);
    w.sprite_columns = COORD_W'(cols);
    w.sprite_rows    = ROWS_W'(rows);
    w.column_number  = COORD_W'(colno);
    w.column_pixels  = pix;
    w.page_number    = PAGE_W'(page);
    w.screen_column  = SCOL_W'(scol);
    return w;
  endfunction

  // blit model: updates the frame and gives the read result, if any
  task automatic predict_blit(input blit_item_t w, output bit has_res, output blit_res_t res);
    int rows, sx, sy, wx, ys, ye, up, down, i;
    bit vis;
    logic [WORD_W-1:0] smask, scmask, word, bits;
    has_res = 1'b0;
    res     = RES_ZERO;
    vis     = 1'b0;
    up      = 0;
    down    = 0;
    wx      = 0;
    smask   = '0;
    scmask  = '0;
    case (w.op)
      OP_CLEAR: begin
        for (i = 0; i < SCREEN_WIDTH; i++) frame_model[i] = '0;
      end
      OP_READ_BYTE: begin
        has_res = 1'b1;
        word = frame_model[w.screen_column] >> (int'(w.page_number) * 8);
        res.display_byte = word[BYTE_W-1:0];
      end
      OP_DRAW_OR, OP_DRAW_SET, OP_READ_COL: begin
        rows = (w.sprite_rows > 64) ? 64 : int'(w.sprite_rows);
        sx   = int'(w.sprite_left);
        sy   = int'(w.sprite_top);
        // clip against the camera window, full-width sums
        if (w.column_number < w.sprite_columns) begin
          wx = sx + int'(w.column_number);
          ys = (sy > cam_top_m) ? sy : cam_top_m;
          ye = (sy + rows < cam_top_m + SCREEN_HEIGHT) ? sy + rows : cam_top_m + SCREEN_HEIGHT;
          if (wx >= cam_left_m && wx < cam_left_m + SCREEN_WIDTH && ys < ye) begin
            vis   = 1'b1;
            smask = mask_below(ye - sy) & ~mask_below(ys - sy);
            if (sy >= cam_top_m) begin
              up     = sy - cam_top_m;
              scmask = smask << up;
            end else begin
              down   = cam_top_m - sy;
              scmask = smask >> down;
            end
          end
        end
        if (w.op == OP_READ_COL) begin
          has_res = 1'b1;
          res.column_visible = vis;
          if (vis) begin
            word = frame_model[wx - cam_left_m];
            res.read_pixels = ((down != 0) ? (word << down) : (word >> up)) & smask;
          end
        end else if (vis) begin
          bits = w.column_pixels & smask;
          bits = (down != 0) ? (bits >> down) : (bits << up);
          if (w.op == OP_DRAW_SET) frame_model[wx - cam_left_m] &= ~scmask;
          frame_model[wx - cam_left_m] |= bits & scmask;
        end
      end
      default: ;
    endcase
  endtask

  // random word, mostly placed around the camera window
  function automatic blit_item_t rand_word(int cl, int ct);
    blit_item_t w;
    int pick, sx, sy, cols, rows, colno;
    logic [WORD_W-1:0] pix;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 2)       op = OP_CLEAR;
    else if (pick < 5)  op = OP_SPARE_5 + 3'($urandom_range(0, 2));
    else if (pick < 40) op = OP_DRAW_OR;
    else if (pick < 62) op = OP_DRAW_SET;
    else if (pick < 82) op = OP_READ_COL;
    else                op = OP_READ_BYTE;
    if ($urandom_range(0, 9) < 3) sx = $urandom_range(0, 255);
    else sx = cl - 12 + $urandom_range(0, 150);
    if ($urandom_range(0, 9) < 3) sy = $urandom_range(0, 255);
    else sy = ct - 20 + $urandom_range(0, 100);
    sx = (sx < 0) ? 0 : (sx > 255) ? 255 : sx;
    sy = (sy < 0) ? 0 : (sy > 255) ? 255 : sy;
    pick = $urandom_range(0, 99);
    cols = (pick < 5) ? 0 : (pick < 10) ? 255 : $urandom_range(1, 16);
    if (cols > 0 && $urandom_range(0, 9) < 8) colno = $urandom_range(0, cols - 1);
    else colno = $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    rows = (pick < 5) ? 0 : (pick < 15) ? $urandom_range(65, 127) : $urandom_range(1, 64);
    pick = $urandom_range(0, 99);
    pix  = (pick < 10) ? '1 : (pick < 15) ? '0 : {$urandom, $urandom};
    w = mk(op, sx, sy, cols, rows, colno, pix, $urandom_range(0, 7), $urandom_range(0, 127));
    return w;
  endfunction

  // one word: optional gap, then hold until accepted
  task automatic send_word(input blit_item_t w, input bit typed, input blit_res_t res);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_word(w);
    s_axis_tuser  <= w.op;
    drv_item      <= w;
    drv_typed     <= typed;
    drv_typed_res <= res;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (w.op == OP_DRAW_OR || w.op == OP_DRAW_SET) draws_sent++;
  endtask

  // stop sending, wait for every pending result, then let the block settle
  task automatic wait_drained(input int tail);
    s_axis_tvalid <= 1'b0;
    // let the monitor queue the last accepted word before the pending results are checked
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_camera(input int cl, input int ct);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CAMERA_LEFT;
    cfg_data_i  <= CFG_DATA_W'(cl);
    @(posedge clk_i);
    cfg_index_i <= CFG_CAMERA_TOP;
    cfg_data_i  <= CFG_DATA_W'(ct);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // model update on accepted words, check on accepted results
  always @(posedge clk_i) begin
    blit_res_t got, want;
    bit has;
    if (!rst_ni) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      cam_left_m = 0;
      cam_top_m  = 0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CAMERA_LEFT) cam_left_m = int'(cfg_data_i);
        else cam_top_m = int'(cfg_data_i);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_pixels    = m_axis_tdata[WORD_W-1:0];
        got.display_byte   = m_axis_tdata[WORD_W +: BYTE_W];
        got.column_visible = m_axis_tuser[0];
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: read_pixels %h", got.read_pixels);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.read_pixels !== want.read_pixels) begin
            $error("read_pixels: expected %h, got %h", want.read_pixels, got.read_pixels);
            errors++;
          end
          if (got.column_visible !== want.column_visible) begin
            $error("column_visible: expected %0d, got %0d",
                   want.column_visible, got.column_visible);
            errors++;
          end
          if (got.display_byte !== want.display_byte) begin
            $error("display_byte: expected %h, got %h", want.display_byte, got.display_byte);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_blit(drv_item, has, want);
        if (has) pending_results.push_back(drv_typed ? drv_typed_res : want);
      end
    end
  end

  initial begin
    int cl_set [NUM_PASSES];
    int ct_set [NUM_PASSES];
    int snd_set [NUM_PASSES];
    int rcv_set [NUM_PASSES];
    int p, k;

    // directed rows: reset state, extremes, clipping corners, spare codes
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 0, 0), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 7, 127), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 0, 0, 1, 64, 0, '0, 0, 0), 1'b1, RES_ZERO_VIS});
    dir_rows.push_back('{mk(OP_DRAW_OR, 0, 0, 1, 64, 0, '1, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 0, 0, 1, 64, 0, '0, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 7, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_DRAW_SET, 0, 0, 1, 8, 0, '0, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 0, 0), 1'b0, RES_ZERO});
    // column past the sprite's width
    dir_rows.push_back('{mk(OP_READ_COL, 0, 0, 5, 64, 5, '0, 0, 0), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_DRAW_OR, 0, 0, 5, 64, 7, '1, 0, 0), 1'b0, RES_ZERO});
    // sprite taller than the word
    dir_rows.push_back('{mk(OP_DRAW_OR, 127, 0, 1, 127, 0, 64'hA5C3_0FF0_5A3C_F00F, 0, 0),
                         1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 127, 0, 1, 127, 0, '0, 0, 0), 1'b0, RES_ZERO});
    // empty sprites
    dir_rows.push_back('{mk(OP_DRAW_OR, 20, 10, 0, 8, 0, '1, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 20, 10, 4, 0, 0, '0, 0, 0), 1'b1, RES_ZERO});
    // spare codes, two of them with every field at its top
    dir_rows.push_back('{mk(OP_SPARE_5, 255, 255, 255, 127, 255, '1, 7, 127), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_SPARE_6, 0, 0, 1, 64, 0, '1, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_SPARE_7, 255, 255, 255, 127, 255, '1, 7, 127), 1'b0, RES_ZERO});
    // sprite clipped at the bottom edge
    dir_rows.push_back('{mk(OP_DRAW_SET, 100, 60, 8, 64, 3, 64'h1234_5678_9ABC_DEF1, 0, 0),
                         1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 100, 60, 8, 64, 3, '0, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 7, 103), 1'b0, RES_ZERO});
    // frame clear, then reads of the extremes
    dir_rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, '0, 0, 0), 1'b0, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_BYTE, 0, 0, 0, 0, 0, '0, 7, 127), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 127, 0, 1, 127, 0, '0, 0, 0), 1'b1, RES_ZERO_VIS});
    dir_rows.push_back('{mk(OP_READ_COL, 255, 255, 255, 127, 255, '0, 0, 0), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 255, 0, 255, 64, 0, '0, 0, 0), 1'b1, RES_ZERO});
    dir_rows.push_back('{mk(OP_READ_COL, 0, 255, 1, 64, 0, '0, 0, 0), 1'b1, RES_ZERO});

    // camera and idling per pass
    cl_set  = '{0, 255, 0, 255, $urandom_range(0, 255), $urandom_range(0, 255)};
    ct_set  = '{0, 255, 255, 0, $urandom_range(0, 255), $urandom_range(0, 255)};
    snd_set = '{0, 82, 0, 28, 0, 82};
    rcv_set = '{0, 0, 82, 28, 0, 28};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    wait_drained(DRAIN_TAIL);

    for (p = 0; p < NUM_PASSES; p++) begin
      write_camera(cl_set[p], ct_set[p]);
      sender_idle_pct = snd_set[p];
      recv_stall_pct  = rcv_set[p];
      for (k = 0; k < WORDS_PER_PASS; k++) begin
        // one pass holds off mid-way until all results are back
        if (p == 4 && k == WORDS_PER_PASS / 2) wait_drained(1);
        send_word(rand_word(cl_set[p], ct_set[p]), 1'b0, RES_ZERO);
      end
      wait_drained(DRAIN_TAIL);
    end

    $display("covered %0d words (%0d draws) under %0d camera settings, %0d results checked",
             words_sent, draws_sent, NUM_PASSES, results_checked);
    if (errors == 0) begin
      $display("clipped_sprite_blit_framebuffer_tb: clean");
    end else begin
      $display("clipped_sprite_blit_framebuffer_tb: errors");
    end
    $finish;
  end

endmodule
